// File: rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, muted while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check on the rising edge of clk, active during reset too.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/aes128ke_pkg.sv
// Constants, S-box, rcon and RotWord/SubWord functions of the AES-128 key expansion.
package aes128ke_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RoundW    = 4;
  localparam int unsigned KeyW      = 128;
  localparam int unsigned HalfW     = 64;
  localparam int unsigned WordW     = 32;
  localparam int unsigned ByteW     = 8;

  localparam logic [RoundW-1:0] FirstRound = RoundW'(1);
  localparam logic [RoundW-1:0] LastRound  = RoundW'(NumRounds);

  localparam logic [ByteW-1:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Round constant for rounds 1 to 10; other codes give 8'h00.
  function automatic logic [ByteW-1:0] rcon_of(input logic [RoundW-1:0] rnd);
    logic [ByteW-1:0] rc;
    case (rnd)
      4'd1:    rc = 8'h01;
      4'd2:    rc = 8'h02;
      4'd3:    rc = 8'h04;
      4'd4:    rc = 8'h08;
      4'd5:    rc = 8'h10;
      4'd6:    rc = 8'h20;
      4'd7:    rc = 8'h40;
      4'd8:    rc = 8'h80;
      4'd9:    rc = 8'h1b;
      4'd10:   rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  // RotWord then SubWord, first byte of the word in bits 7:0.
  function automatic logic [WordW-1:0] sub_rot(input logic [WordW-1:0] w);
    logic [WordW-1:0] r;
    logic [WordW-1:0] s;
    r = {w[ByteW-1:0], w[WordW-1:ByteW]};
    for (int b = 0; b < WordW / ByteW; b++) begin
      s[b*ByteW +: ByteW] = SBOX[r[b*ByteW +: ByteW]];
    end
    return s;
  endfunction

endpackage

// File: rtl/aes128_key_expansion.sv
// AES-128 key expansion: one key in, round keys 1 to 10 out, one per unstalled cycle.
//
//  channel   | dir | tdata                                  | tuser          | tlast
//  s_axis    | in  | key_low [63:0], key_high [127:64]      | -              | -
//  m_axis    | out | round_key_low [63:0], _high [127:64]   | round_number   | last_round
//
// One round key is computed per cycle, unless m_axis stalls, by four S-box lookups
// and an XOR chain between the working key register and the output register.
// The next key is taken in the same cycle as round 10 of the current one leaves the
// round logic, so keys follow back to back with no gap.
// A stall on m_axis holds the output register and the round counter.
// rst is synchronous and clears the busy and valid flags and the round counter.
`include "assert_macros.svh"

module aes128_key_expansion
  import aes128ke_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [KeyW-1:0]   s_tdata,   // key_low [63:0], key_high [127:64]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [KeyW-1:0]   m_tdata,   // round_key_low [63:0], round_key_high [127:64]
  output logic [RoundW-1:0] m_tuser,   // round_number [3:0]
  output logic              m_tlast    // last_round
);

  logic              busy;
  logic [RoundW-1:0] rnd;
  logic [KeyW-1:0]   cur_key;
  logic [KeyW-1:0]   cur_key_next;
  logic              advance;
  logic              accept;

  logic [WordW-1:0] w0, w1, w2, w3, t;

  assign advance  = busy && (!m_tvalid || m_tready);
  assign s_tready = !busy || (advance && rnd == LastRound);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    t  = sub_rot(cur_key[4*WordW-1:3*WordW]) ^ {{(WordW-ByteW){1'b0}}, rcon_of(rnd)};
    w0 = cur_key[WordW-1:0] ^ t;
    w1 = cur_key[2*WordW-1:WordW] ^ w0;
    w2 = cur_key[3*WordW-1:2*WordW] ^ w1;
    w3 = cur_key[4*WordW-1:3*WordW] ^ w2;
    cur_key_next = {w3, w2, w1, w0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      rnd  <= FirstRound;
    end else if (advance) begin
      if (rnd == LastRound) begin
        busy <= 1'b0;
      end else begin
        rnd <= rnd + RoundW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_key <= s_tdata;
    end else if (advance) begin
      cur_key <= cur_key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= cur_key_next;
      m_tuser <= rnd;
      m_tlast <= (rnd == LastRound);
    end
  end

  `ASSERT_CLK(a_round_range, m_tvalid |-> (m_tuser != '0 && m_tuser <= LastRound),
              "round number out of range")
  `ASSERT_CLK(a_last_flag, m_tvalid |-> (m_tlast == (m_tuser == LastRound)),
              "tlast disagrees with round number")
  `ASSERT_CLK(a_accept_gap, accept |-> (!busy || (advance && rnd == LastRound)),
              "key taken mid-expansion")
  `ASSERT_CLK(a_round_step,
              (advance && !accept && rnd != LastRound) |=> (rnd == $past(rnd) + RoundW'(1)),
              "round counter skipped")
  `ASSERT_CLK(a_hold_stall,
              (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser) && $stable(m_tdata)),
              "output changed under stall")

endmodule
